>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge out of reset.
`define MWUF_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// When the first condition holds, the second holds in the next cycle.
`define MWUF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/mwuf_pkg.sv
// ----------------------------------------------------------------------------
// mwuf_pkg
// Shared constants and types of the maze wall union-find block.
// ----------------------------------------------------------------------------
package mwuf_pkg;

    localparam int MAX_SIDE_DEFAULT = 64;
    localparam int SIDE_RESET       = 8;
    localparam int CELL_FIELD_W     = 12;
    localparam int CFG_DATA_W       = 7;
    localparam int CFG_INDEX_W      = 1;
    localparam int IN_DATA_W        = 24;
    localparam int OUT_DATA_W       = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT    = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COLUMN_COUNT = 1'd1;

    typedef struct packed {
        logic done;
        logic zero;
    } rem_status_t;

endpackage

>>> rtl/mwuf_rem.sv
// ----------------------------------------------------------------------------
// mwuf_rem
// Iterative restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mwuf_rem #(
    parameter int DIV_W  = 13,
    parameter int SIDE_W = 7
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [DIV_W-1:0]       dividend,
    input  logic [SIDE_W-1:0]      divisor,
    output mwuf_pkg::rem_status_t  status
);

    localparam int SH_W  = DIV_W + SIDE_W;
    localparam int CNT_W = (SIDE_W > 1) ? $clog2(SIDE_W) : 1;

    logic [DIV_W-1:0] rem_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [SH_W-1:0]  shifted;
    logic [SH_W-1:0]  rem_ext;
    logic             fits;

    assign shifted = SH_W'(divisor) << cnt_reg;
    assign rem_ext = SH_W'(rem_reg);
    assign fits    = rem_ext >= shifted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SIDE_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
        end
        else if (busy_reg && fits)
        begin
            rem_reg <= DIV_W'(rem_ext - shifted);
        end
    end

    assign status.done = done_reg;
    assign status.zero = (rem_reg == '0);

endmodule

>>> rtl/mwuf_parent_mem.sv
// ----------------------------------------------------------------------------
// mwuf_parent_mem
// Parent store of the union-find: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mwuf_parent_mem #(
    parameter int CELL_W = 12,
    parameter int DEPTH  = 4096
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [CELL_W-1:0] wr_addr,
    input  logic [CELL_W-1:0] wr_data,
    input  logic [CELL_W-1:0] rd_addr,
    output logic [CELL_W-1:0] rd_data
);

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

>>> rtl/maze_wall_union_find.sv
// ----------------------------------------------------------------------------
// maze_wall_union_find
// Kruskal-style maze carving: each request tries a right wall and a bottom
// wall and merges the two sets of cells when the wall opens.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_axis    in         right_cell, below_cell
// m_axis    out        right_opened, bottom_opened
// cfg       in         row_count (index 0), column_count (index 1)
//
// A request passes the divide step, then per wall a wall check and, for a tried wall,
// a root search for both cells (one link per cycle) and a link step, then a done state.
// After reset a clearing pass fills the parent memory before the first request is
// taken. A result waits in the output register while the next request is accepted;
// the next result then stalls the block until the sink takes the one before it.
// ----------------------------------------------------------------------------
module maze_wall_union_find #(
    parameter int MAX_SIDE = mwuf_pkg::MAX_SIDE_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // right_cell [11:0], below_cell [23:12]
    input  logic [mwuf_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // right_opened [0], bottom_opened [1], zeros above
    output logic [mwuf_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic                              cfg_wr_en,
    input  logic [mwuf_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [mwuf_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
    localparam int CELL_W     = $clog2(DEPTH);
    localparam int SIDE_W     = $clog2(MAX_SIDE + 1);
    localparam int DIV_W      = CELL_W + 1;
    localparam int PROD_W     = 2 * SIDE_W;
    localparam int CMP_W      = PROD_W + mwuf_pkg::CELL_FIELD_W;
    localparam int RESET_SIDE = (MAX_SIDE < mwuf_pkg::SIDE_RESET) ? MAX_SIDE
                                                                  : mwuf_pkg::SIDE_RESET;
    localparam int FW         = mwuf_pkg::CELL_FIELD_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_WALL,
        ST_FIND,
        ST_LINK,
        ST_DONE
    } state_t;

    state_t            state_reg,       state_next;
    logic [CELL_W-1:0] clr_cnt_reg,     clr_cnt_next;
    logic [SIDE_W-1:0] rows_reg,        rows_next;
    logic [SIDE_W-1:0] cols_reg,        cols_next;
    logic [FW-1:0]     rc_reg,          rc_next;
    logic [FW-1:0]     bc_reg,          bc_next;
    logic              right_ok_reg,    right_ok_next;
    logic              bottom_ok_reg,   bottom_ok_next;
    logic              wall_sel_reg,    wall_sel_next;
    logic              side_reg,        side_next;
    logic [CELL_W-1:0] cur_reg,         cur_next;
    logic [CELL_W-1:0] ra_reg,          ra_next;
    logic [CELL_W-1:0] rb_reg,          rb_next;
    logic              right_open_reg,  right_open_next;
    logic              bottom_open_reg, bottom_open_next;
    logic              out_valid_reg,   out_valid_next;
    logic              out_right_reg,   out_right_next;
    logic              out_bottom_reg,  out_bottom_next;

    logic [PROD_W-1:0] cells;
    logic [PROD_W-1:0] bottom_lim;
    logic              rc_in_grid;
    logic              bc_in_grid;
    logic              bc_above_last;
    logic [CELL_W-1:0] a_cell;
    logic [CELL_W-1:0] b_cell;
    logic              wall_ok;
    logic              in_accept;
    logic [DIV_W-1:0]  rem_dividend;

    logic              wr_en;
    logic [CELL_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic [CELL_W-1:0] rd_data;

    mwuf_pkg::rem_status_t rem_st;

    function automatic logic [SIDE_W-1:0] clamp_side(
        input logic [mwuf_pkg::CFG_DATA_W-1:0] v
    );
        logic [SIDE_W-1:0] r;
        if (v == '0)
        begin
            r = SIDE_W'(1);
        end
        else if (int'(v) > MAX_SIDE)
        begin
            r = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            r = SIDE_W'(v);
        end
        return r;
    endfunction

    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign rem_dividend  = DIV_W'(s_axis_tdata[FW-1:0]) + DIV_W'(1);

    assign cells         = PROD_W'(rows_reg) * PROD_W'(cols_reg);
    assign bottom_lim    = PROD_W'(cols_reg) * PROD_W'(rows_reg - 1'b1);
    assign rc_in_grid    = CMP_W'(rc_reg) < CMP_W'(cells);
    assign bc_in_grid    = CMP_W'(bc_reg) < CMP_W'(cells);
    assign bc_above_last = CMP_W'(bc_reg) < CMP_W'(bottom_lim);

    assign a_cell  = wall_sel_reg ? CELL_W'(bc_reg) : CELL_W'(rc_reg);
    assign b_cell  = wall_sel_reg ? CELL_W'(bc_reg) + CELL_W'(cols_reg)
                                  : CELL_W'(rc_reg) + CELL_W'(1);
    assign wall_ok = wall_sel_reg ? bottom_ok_reg : right_ok_reg;

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = ra_reg;
        wr_data = rb_reg;
        if (state_reg == ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg;
            wr_data = clr_cnt_reg;
        end
        else if (state_reg == ST_LINK)
        begin
            wr_en = (ra_reg != rb_reg);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        rows_next        = rows_reg;
        cols_next        = cols_reg;
        rc_next          = rc_reg;
        bc_next          = bc_reg;
        right_ok_next    = right_ok_reg;
        bottom_ok_next   = bottom_ok_reg;
        wall_sel_next    = wall_sel_reg;
        side_next        = side_reg;
        cur_next         = cur_reg;
        ra_next          = ra_reg;
        rb_next          = rb_reg;
        right_open_next  = right_open_reg;
        bottom_open_next = bottom_open_reg;
        out_valid_next   = out_valid_reg && !m_axis_tready;
        out_right_next   = out_right_reg;
        out_bottom_next  = out_bottom_reg;

        if (cfg_wr_en)
        begin
            case (cfg_index)
                mwuf_pkg::REG_ROW_COUNT:    rows_next = clamp_side(cfg_data);
                mwuf_pkg::REG_COLUMN_COUNT: cols_next = clamp_side(cfg_data);
                default: ;
            endcase
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == CELL_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    rc_next    = s_axis_tdata[FW-1:0];
                    bc_next    = s_axis_tdata[2*FW-1:FW];
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_st.done)
                begin
                    right_ok_next  = rc_in_grid && !rem_st.zero;
                    bottom_ok_next = bc_in_grid && bc_above_last;
                    wall_sel_next  = 1'b0;
                    state_next     = ST_WALL;
                end
            end
            ST_WALL:
            begin
                if (wall_ok)
                begin
                    cur_next   = a_cell;
                    side_next  = 1'b0;
                    state_next = ST_FIND;
                end
                else if (wall_sel_reg)
                begin
                    bottom_open_next = 1'b0;
                    state_next       = ST_DONE;
                end
                else
                begin
                    right_open_next = 1'b0;
                    wall_sel_next   = 1'b1;
                end
            end
            ST_FIND:
            begin
                if (rd_data != cur_reg)
                begin
                    cur_next = rd_data;
                end
                else if (!side_reg)
                begin
                    ra_next   = cur_reg;
                    side_next = 1'b1;
                    cur_next  = b_cell;
                end
                else
                begin
                    rb_next    = cur_reg;
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                if (wall_sel_reg)
                begin
                    bottom_open_next = (ra_reg != rb_reg);
                    state_next       = ST_DONE;
                end
                else
                begin
                    right_open_next = (ra_reg != rb_reg);
                    wall_sel_next   = 1'b1;
                    state_next      = ST_WALL;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next  = 1'b1;
                    out_right_next  = right_open_reg;
                    out_bottom_next = bottom_open_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            rows_reg      <= SIDE_W'(RESET_SIDE);
            cols_reg      <= SIDE_W'(RESET_SIDE);
            wall_sel_reg  <= 1'b0;
            side_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            rows_reg      <= rows_next;
            cols_reg      <= cols_next;
            wall_sel_reg  <= wall_sel_next;
            side_reg      <= side_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rc_reg          <= rc_next;
        bc_reg          <= bc_next;
        right_ok_reg    <= right_ok_next;
        bottom_ok_reg   <= bottom_ok_next;
        cur_reg         <= cur_next;
        ra_reg          <= ra_next;
        rb_reg          <= rb_next;
        right_open_reg  <= right_open_next;
        bottom_open_reg <= bottom_open_next;
        out_right_reg   <= out_right_next;
        out_bottom_reg  <= out_bottom_next;
    end

    mwuf_rem #(
        .DIV_W  (DIV_W),
        .SIDE_W (SIDE_W)
    ) u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .dividend (rem_dividend),
        .divisor  (cols_reg),
        .status   (rem_st)
    );

    mwuf_parent_mem #(
        .CELL_W (CELL_W),
        .DEPTH  (DEPTH)
    ) u_parent_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (cur_next),
        .rd_data (rd_data)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mwuf_pkg::OUT_DATA_W - 2){1'b0}}, out_bottom_reg, out_right_reg};

`include "assert_macros.svh"

    `MWUF_ASSERT_NEXT(a_accept_divides, in_accept, state_reg == ST_DIVIDE)
    `MWUF_ASSERT_NEXT(a_clear_runs, (state_reg == ST_CLEAR) && (clr_cnt_reg != CELL_W'(DEPTH - 1)), state_reg == ST_CLEAR)
    `MWUF_ASSERT(a_done_after_bottom, (state_reg != ST_DONE) || wall_sel_reg)
    `MWUF_ASSERT(a_result_from_done, !$rose(m_axis_tvalid) || ($past(state_reg) == ST_DONE))

endmodule

>>> dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for maze_wall_union_find. Wall requests go in on the
// slave stream and the opened flags come back on the master stream. A
// union-find model of the carver predicts each result at request accept.
// The grid size changes between phases while both sides stall at random in most phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CELL_SPACE = mwuf_pkg::MAX_SIDE_DEFAULT * mwuf_pkg::MAX_SIDE_DEFAULT;
    localparam int FW         = mwuf_pkg::CELL_FIELD_W;
    localparam int DW         = mwuf_pkg::CFG_DATA_W;

    typedef struct packed {
        logic [FW-1:0] below_cell;
        logic [FW-1:0] right_cell;
    } wall_pair_t;

    typedef struct packed {
        logic bottom_opened;
        logic right_opened;
    } opened_t;

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 s_axis_tvalid = 1'b0;
    logic                                 s_axis_tready;
    logic [mwuf_pkg::IN_DATA_W-1:0]       s_axis_tdata = '0;
    logic                                 m_axis_tvalid;
    logic                                 m_axis_tready = 1'b0;
    logic [mwuf_pkg::OUT_DATA_W-1:0]      m_axis_tdata;
    logic                                 cfg_wr_en = 1'b0;
    logic [mwuf_pkg::CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [DW-1:0]                        cfg_data = '0;

    logic [FW-1:0] cell_link [CELL_SPACE];
    logic [DW-1:0] grid_rows;
    logic [DW-1:0] grid_cols;

    wall_pair_t wall_requests [$];
    opened_t    opened_expected [$];
    opened_t    carved;

    bit idle_enable = 1'b1;
    int send_gap;
    int sink_gap;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int walls_opened = 0;
    int phases_run = 0;
    int random_items = 0;

    maze_wall_union_find u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int grid_side(logic [DW-1:0] value);
        if (value == 0)
            return 1;
        if (value > mwuf_pkg::MAX_SIDE_DEFAULT)
            return mwuf_pkg::MAX_SIDE_DEFAULT;
        return int'(value);
    endfunction

    function automatic logic [FW-1:0] set_root(logic [FW-1:0] start_cell);
        logic [FW-1:0] cur;
        cur = start_cell;
        for (int hop = 0; hop < CELL_SPACE; hop++)
        begin
            if (cell_link[cur] == cur)
                break;
            cur = cell_link[cur];
        end
        return cur;
    endfunction

    function automatic logic merge_sets(logic [FW-1:0] a, logic [FW-1:0] b);
        logic [FW-1:0] root_a;
        logic [FW-1:0] root_b;
        root_a = set_root(a);
        root_b = set_root(b);
        if (root_a == root_b)
            return 1'b0;
        cell_link[root_a] = root_b;
        return 1'b1;
    endfunction

    function automatic opened_t carve_walls(wall_pair_t walls);
        int      rows;
        int      cols;
        int      cells;
        int      rc;
        int      bc;
        opened_t res;
        rows  = grid_side(grid_rows);
        cols  = grid_side(grid_cols);
        cells = rows * cols;
        rc    = int'(walls.right_cell);
        bc    = int'(walls.below_cell);
        res   = '0;
        if (rc < cells && ((rc + 1) % cols) != 0)
            res.right_opened = merge_sets(rc[FW-1:0], FW'(rc + 1));
        if (bc < cells && bc < cols * (rows - 1))
            res.bottom_opened = merge_sets(bc[FW-1:0], FW'(bc + cols));
        return res;
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        $display("MISMATCH at %0t ns: %s", $time, what);
    endtask

    task automatic check_result(logic [mwuf_pkg::OUT_DATA_W-1:0] data);
        opened_t want;
        if (opened_expected.size() == 0)
        begin
            report_mismatch($sformatf("result 0x%0h with no request outstanding", data));
        end
        else
        begin
            want = opened_expected.pop_front();
            results_checked++;
            if (data[0] !== want.right_opened)
                report_mismatch($sformatf("result %0d: right_opened %b, expected %b",
                                          results_checked, data[0], want.right_opened));
            if (data[1] !== want.bottom_opened)
                report_mismatch($sformatf("result %0d: bottom_opened %b, expected %b",
                                          results_checked, data[1], want.bottom_opened));
            walls_opened += int'(want.right_opened) + int'(want.bottom_opened);
        end
    endtask

    // Request driver: the model is advanced at the edge where a request is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                carved = carve_walls(wall_pair_t'(s_axis_tdata));
                opened_expected.push_back(carved);
                requests_sent++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (wall_requests.size() > 0)
                begin
                    if (idle_enable && $urandom_range(0, 7) == 0)
                    begin
                        send_gap = $urandom_range(0, 18);
                        s_axis_tvalid <= 1'b0;
                    end
                    else
                    begin
                        s_axis_tdata  <= wall_requests.pop_front();
                        s_axis_tvalid <= 1'b1;
                    end
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            sink_gap = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result(m_axis_tdata);
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_enable && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic wait_idle();
        do
            @(negedge clk);
        while (wall_requests.size() != 0 || s_axis_tvalid || opened_expected.size() != 0);
    endtask

    task automatic write_register(logic [mwuf_pkg::CFG_INDEX_W-1:0] index,
                                  logic [DW-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        if (index == mwuf_pkg::REG_ROW_COUNT)
            grid_rows = value;
        else
            grid_cols = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic push_walls(int right_cell, int below_cell);
        wall_pair_t walls;
        walls.right_cell = right_cell[FW-1:0];
        walls.below_cell = below_cell[FW-1:0];
        wall_requests.push_back(walls);
    endtask

    // Mostly a shuffled wall order over the grid, as in maze carving, with
    // some random cells, cells just past the grid and repeated walls mixed in.
    task automatic run_phase(logic [DW-1:0] rows_value,
                             logic [DW-1:0] cols_value, int count, bit idle);
        int right_order[];
        int below_order[];
        int cells;
        int pos;
        int pick;
        int j;
        int tmp;
        write_register(mwuf_pkg::REG_ROW_COUNT, rows_value);
        write_register(mwuf_pkg::REG_COLUMN_COUNT, cols_value);
        idle_enable = idle;
        cells = grid_side(rows_value) * grid_side(cols_value);
        right_order = new[cells];
        below_order = new[cells];
        for (int i = 0; i < cells; i++)
        begin
            right_order[i] = i;
            below_order[i] = i;
        end
        for (int i = cells - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = right_order[i];
            right_order[i] = right_order[j];
            right_order[j] = tmp;
            j = $urandom_range(0, i);
            tmp = below_order[i];
            below_order[i] = below_order[j];
            below_order[j] = tmp;
        end
        pos = 0;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                push_walls($urandom_range(0, CELL_SPACE - 1),
                           (cells + $urandom_range(0, 7)) % CELL_SPACE);
            end
            else if (pick == 1 && pos > 0)
            begin
                j = $urandom_range(0, pos - 1);
                push_walls(right_order[j], below_order[j]);
            end
            else
            begin
                push_walls(right_order[pos % cells], below_order[pos % cells]);
                pos++;
            end
        end
        random_items += count;
        wait_idle();
        phases_run++;
    endtask

    initial
    begin
        int rows_pick;
        int cols_pick;
        int cells;
        for (int i = 0; i < CELL_SPACE; i++)
            cell_link[i] = i[FW-1:0];
        grid_rows = DW'(mwuf_pkg::SIDE_RESET);
        grid_cols = DW'(mwuf_pkg::SIDE_RESET);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset grid of 8 by 8: edges, corners, out-of-grid cells and repeats.
        push_walls(0, 0);
        push_walls(7, 56);
        push_walls(63, 63);
        push_walls(64, 4095);
        push_walls(4095, 64);
        push_walls(1, 1);
        push_walls(0, 0);
        push_walls(2730, 1365);
        push_walls(1365, 2730);
        push_walls(62, 55);
        push_walls(8, 9);
        push_walls(6, 48);
        push_walls(15, 57);
        push_walls(9, 2);
        push_walls(56, 47);
        push_walls(2, 8);
        wait_idle();
        phases_run++;

        run_phase(7'd1, 7'd20, 20, 1'b1);
        run_phase(7'd30, 7'd1, 30, 1'b1);
        run_phase(7'd0, 7'd0, 10, 1'b1);
        run_phase(7'd127, 7'd127, 250, 1'b1);
        run_phase(7'd65, 7'd3, 150, 1'b0);
        run_phase(7'd12, 7'd10, 120, 1'b1);
        run_phase(7'd2, 7'd64, 128, 1'b1);
        while (random_items < 1420)
        begin
            rows_pick = $urandom_range(1, 24);
            cols_pick = $urandom_range(1, 24);
            if ($urandom_range(0, 7) == 0)
                rows_pick = ($urandom_range(0, 1) == 0) ? 0 : 64 + $urandom_range(0, 63);
            if ($urandom_range(0, 7) == 0)
                cols_pick = ($urandom_range(0, 1) == 0) ? 1 : 64 + $urandom_range(0, 63);
            cells = grid_side(rows_pick[DW-1:0]) * grid_side(cols_pick[DW-1:0]);
            run_phase(rows_pick[DW-1:0], cols_pick[DW-1:0],
                      (cells < 40) ? 40 : ((cells > 160) ? $urandom_range(40, 160) : cells),
                      $urandom_range(0, 3) != 0);
        end
        run_phase(7'd9, 7'd7, 63, 1'b0);

        repeat (200) @(posedge clk);
        $display("Checked %0d results for %0d wall requests over %0d grid settings.",
                 results_checked, requests_sent, phases_run);
        $display("Grids ran from one cell to 64 by 64; %0d walls were opened.", walls_opened);
        if (error_count == 0 && opened_expected.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
